// File: rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types, constants and round functions of the TEA1 short key search.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int KEYSTREAM_BYTES = 4;
  localparam int PACKED_BYTES    = 4;
  localparam int FIRST_SKIP      = 54;
  localparam int NEXT_SKIP       = 19;
  localparam int NUM_BYTES       = (KEYSTREAM_BYTES < PACKED_BYTES) ? KEYSTREAM_BYTES
                                                                    : PACKED_BYTES;
  localparam int ROUNDS          = FIRST_SKIP + NEXT_SKIP * (NUM_BYTES - 1);
  localparam int KS_ALIGN        = 8 * (PACKED_BYTES - NUM_BYTES);

  localparam logic [31:0] IV_XOR_CONST = 32'h9672_4FA1;
  localparam logic [31:0] MATCH_MASK   = 32'hFFFF_FFFF << KS_ALIGN;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_IV   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_IV  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_XOR_TARGET = 2'd2;

  localparam logic [15:0] LUT_A [8] = '{
    16'hDA86, 16'h85E9, 16'h29B5, 16'h2BC6, 16'h8C6B, 16'h974C, 16'hC671, 16'h93E2};
  localparam logic [15:0] LUT_B [8] = '{
    16'h85D6, 16'h791A, 16'hE985, 16'hC671, 16'h2B9C, 16'hEC92, 16'hC62B, 16'h9C47};

  localparam logic [7:0] SBOX [256] = '{
    8'h9B, 8'hF8, 8'h3B, 8'h72, 8'h75, 8'h62, 8'h88, 8'h22,
    8'hFF, 8'hA6, 8'h10, 8'h4D, 8'hA9, 8'h97, 8'hC3, 8'h7B,
    8'h9F, 8'h78, 8'hF3, 8'hB6, 8'hA0, 8'hCC, 8'h17, 8'hAB,
    8'h4A, 8'h41, 8'h8D, 8'h89, 8'h25, 8'h87, 8'hD3, 8'hE3,
    8'hCE, 8'h47, 8'h35, 8'h2C, 8'h6D, 8'hFC, 8'hE7, 8'h6A,
    8'hB8, 8'hB7, 8'hFA, 8'h8B, 8'hCD, 8'h74, 8'hEE, 8'h11,
    8'h23, 8'hDE, 8'h39, 8'h6C, 8'h1E, 8'h8E, 8'hED, 8'h30,
    8'h73, 8'hBE, 8'hBB, 8'h91, 8'hCA, 8'h69, 8'h60, 8'h49,
    8'h5F, 8'hB9, 8'hC0, 8'h06, 8'h34, 8'h2A, 8'h63, 8'h4B,
    8'h90, 8'h28, 8'hAC, 8'h50, 8'hE4, 8'h6F, 8'h36, 8'hB0,
    8'hA4, 8'hD2, 8'hD4, 8'h96, 8'hD5, 8'hC9, 8'h66, 8'h45,
    8'hC5, 8'h55, 8'hDD, 8'hB2, 8'hA1, 8'hA8, 8'hBF, 8'h37,
    8'h32, 8'h2B, 8'h3E, 8'hB5, 8'h5C, 8'h54, 8'h67, 8'h92,
    8'h56, 8'h4C, 8'h20, 8'h6B, 8'h42, 8'h9D, 8'hA7, 8'h58,
    8'h0E, 8'h52, 8'h68, 8'h95, 8'h09, 8'h7F, 8'h59, 8'h9C,
    8'h65, 8'hB1, 8'h64, 8'h5E, 8'h4F, 8'hBA, 8'h81, 8'h1C,
    8'hC2, 8'h0C, 8'h02, 8'hB4, 8'h31, 8'h5B, 8'hFD, 8'h1D,
    8'h0A, 8'hC8, 8'h19, 8'h8F, 8'h83, 8'h8A, 8'hCF, 8'h33,
    8'h9E, 8'h3A, 8'h80, 8'hF2, 8'hF9, 8'h76, 8'h26, 8'h44,
    8'hF1, 8'hE2, 8'hC4, 8'hF5, 8'hD6, 8'h51, 8'h46, 8'h07,
    8'h14, 8'h61, 8'hF4, 8'hC1, 8'h24, 8'h7A, 8'h94, 8'h27,
    8'h00, 8'hFB, 8'h04, 8'hDF, 8'h1F, 8'h93, 8'h71, 8'h53,
    8'hEA, 8'hD8, 8'hBD, 8'h3D, 8'hD0, 8'h79, 8'hE6, 8'h7E,
    8'h4E, 8'h9A, 8'hD7, 8'h98, 8'h1B, 8'h05, 8'hAE, 8'h03,
    8'hC7, 8'hBC, 8'h86, 8'hDB, 8'h84, 8'hE8, 8'hD1, 8'hF7,
    8'h16, 8'h21, 8'h6E, 8'hE5, 8'hCB, 8'hA3, 8'h1A, 8'hEC,
    8'hA2, 8'h7D, 8'h18, 8'h85, 8'h48, 8'hDA, 8'hAA, 8'hF0,
    8'h08, 8'hC6, 8'h40, 8'hAD, 8'h57, 8'h0D, 8'h29, 8'h82,
    8'h7C, 8'hE9, 8'h8C, 8'hFE, 8'hDC, 8'h0F, 8'h2D, 8'h3C,
    8'h2E, 8'hF6, 8'h15, 8'h2F, 8'hAF, 8'hE1, 8'hEB, 8'h3F,
    8'h99, 8'h43, 8'h13, 8'h0B, 8'hE0, 8'hA5, 8'h12, 8'h77,
    8'h5D, 8'hB3, 8'h38, 8'hD9, 8'hEF, 8'h5A, 8'h01, 8'h70};

  typedef struct packed {
    logic [31:0] key;
    logic [63:0] st1;
    logic [63:0] st2;
    logic [31:0] ks1;
    logic [31:0] ks2;
    logic [31:0] key_echo;
    logic        range_done;
  } tks_stage_t;

  typedef struct packed {
    logic [31:0] key_echo;
    logic        match;
    logic [31:0] first_keystream;
    logic        found_before;
    logic        range_done;
  } tks_result_t;

  function automatic logic [63:0] tks_expand_iv(input logic [31:0] iv);
    logic [31:0] x;
    logic [63:0] w;
    x = iv ^ IV_XOR_CONST;
    x = {x[23:0], x[31:24]};
    w = {iv, x};
    return {w[7:0], w[63:8]};
  endfunction

  function automatic logic [7:0] tks_derive(input logic [15:0] word, input logic use_b);
    logic [15:0] lo2;
    logic [15:0] hi2;
    logic [7:0]  lo_r;
    logic [7:0]  hi_r;
    logic [3:0]  sel;
    logic [7:0]  res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      lo2  = {word[7:0], word[7:0]} >> i;
      hi2  = {word[15:8], word[15:8]} >> i;
      lo_r = lo2[7:0];
      hi_r = hi2[7:0];
      sel  = {hi_r[2], hi_r[1], lo_r[0], lo_r[7]};
      res[i] = use_b ? LUT_B[i][sel] : LUT_A[i][sel];
    end
    return res;
  endfunction

  function automatic logic [7:0] tks_reorder(input logic [7:0] b);
    return {b[3], b[0], b[4], b[7], b[1], b[5], b[6], b[2]};
  endfunction

  function automatic logic [63:0] tks_lane_step(input logic [63:0] st, input logic [7:0] sb);
    logic [7:0]  d12;
    logic [7:0]  d56;
    logic [7:0]  r4;
    logic [7:0]  nb;
    logic [63:0] sh;
    d12 = tks_derive(st[23:8], 1'b0);
    d56 = tks_derive(st[55:40], 1'b1);
    r4  = tks_reorder(st[39:32]);
    nb  = d56 ^ st[63:56] ^ r4 ^ sb;
    sh  = {st[55:0], 8'h00} ^ {24'h0, d12, 32'h0};
    return {sh[63:8], nb};
  endfunction

  // Round number (1-based) after which a keystream byte is read out.
  function automatic logic tks_is_tap(input int r);
    return (r >= FIRST_SKIP) && (((r - FIRST_SKIP) % NEXT_SKIP) == 0);
  endfunction

endpackage

// File: rtl/tks_in_if.sv
// ----------------------------------------------------------------------------
// tks_in_if
// Candidate key channel: valid/ready handshake with key and end-of-range flag.
// ----------------------------------------------------------------------------
interface tks_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] candidate_key;
  logic        final_candidate;

  modport source (output valid, candidate_key, final_candidate, input ready);
  modport sink   (input valid, candidate_key, final_candidate, output ready);
  modport mon    (input valid, ready, candidate_key, final_candidate);
endinterface

// File: rtl/tks_out_if.sv
// ----------------------------------------------------------------------------
// tks_out_if
// Search result channel: valid/ready handshake with one result per key.
// ----------------------------------------------------------------------------
interface tks_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_echo;
  logic        match;
  logic [31:0] first_keystream;
  logic        found_before;
  logic        range_done;

  modport source (output valid, key_echo, match, first_keystream, found_before,
                  range_done, input ready);
  modport sink   (input valid, key_echo, match, first_keystream, found_before,
                  range_done, output ready);
  modport mon    (input valid, ready, key_echo, match, first_keystream, found_before,
                  range_done);
endinterface

// File: rtl/tea1_short_key_search.sv
// ----------------------------------------------------------------------------
// tea1_short_key_search
// TEA1 keystream short key search: one candidate key per cycle, unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Write first_iv, second_iv and xor_target on the cfg_ port while no item is
//   in flight. Then stream candidate keys on in_ch; each key yields one result
//   on out_ch, in order, with the first IV's keystream, the match flag and a
//   sticky found flag that stays set until reset.
// Pipeline: one stage per cipher round (111 rounds for four keystream bytes),
//   plus the output register.
// Throughput: one item per cycle while in_ch.ready is high; both IV lanes run
//   side by side in each round stage and share the key register update.
// Stall: the round pipeline advances as a whole while the skid register is
//   empty. A stalled result sits in the output register, one more is caught
//   in the skid register, and in_ch.ready then drops until the output drains.
//   in_ch.ready comes from a register only.
// Reset: synchronous, clears all valid bits, the found flag and the config
//   registers (all zero).
// ----------------------------------------------------------------------------
module tea1_short_key_search (
  input  logic                           clk,
  input  logic                           rst_n,
  tks_in_if.sink                         in_ch,
  tks_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import tks_pkg::*;

  logic [31:0] first_iv_r;
  logic [31:0] second_iv_r;
  logic [31:0] xor_target_r;

  logic        en;
  logic        pipe_valid [0:ROUNDS];
  tks_stage_t  pipe_data  [0:ROUNDS];

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic        found_r, found_nxt;
  tks_result_t out_r, out_nxt;
  tks_result_t skid_r, skid_nxt;
  tks_result_t res;
  logic [31:0] ks1_al;
  logic [31:0] ks2_al;
  logic        pop;
  logic        push;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_iv_r   <= '0;
      second_iv_r  <= '0;
      xor_target_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_IV:   first_iv_r   <= cfg_data;
        CFG_SECOND_IV:  second_iv_r  <= cfg_data;
        CFG_XOR_TARGET: xor_target_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en          = !skid_valid_r;
  assign in_ch.ready = en;

  always_comb begin
    pipe_valid[0]           = in_ch.valid;
    pipe_data[0].key        = in_ch.candidate_key;
    pipe_data[0].st1        = tks_expand_iv(first_iv_r);
    pipe_data[0].st2        = tks_expand_iv(second_iv_r);
    pipe_data[0].ks1        = '0;
    pipe_data[0].ks2        = '0;
    pipe_data[0].key_echo   = in_ch.candidate_key;
    pipe_data[0].range_done = in_ch.final_candidate;
  end

  for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
    tks_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .tap     (tks_is_tap(g)),
      .valid_i (pipe_valid[g-1]),
      .data_i  (pipe_data[g-1]),
      .valid_o (pipe_valid[g]),
      .data_o  (pipe_data[g])
    );
  end

  // result build, sticky found, output and skid registers
  always_comb begin
    ks1_al = pipe_data[ROUNDS].ks1 << KS_ALIGN;
    ks2_al = pipe_data[ROUNDS].ks2 << KS_ALIGN;
    pop    = out_valid_r && out_ch.ready;
    push   = en && pipe_valid[ROUNDS];

    res.key_echo        = pipe_data[ROUNDS].key_echo;
    res.match           = ((ks1_al ^ ks2_al) & MATCH_MASK) == (xor_target_r & MATCH_MASK);
    res.first_keystream = ks1_al;
    res.found_before    = found_r | res.match;
    res.range_done      = pipe_data[ROUNDS].range_done;

    found_nxt      = push ? res.found_before : found_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;

    if (skid_valid_r) begin
      if (pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      found_r      <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.key_echo        = out_r.key_echo;
  assign out_ch.match           = out_r.match;
  assign out_ch.first_keystream = out_r.first_keystream;
  assign out_ch.found_before    = out_r.found_before;
  assign out_ch.range_done      = out_r.range_done;
endmodule

// File: rtl/tks_stage.sv
// ----------------------------------------------------------------------------
// tks_stage
// One cipher round for both IV lanes and the shared key register, registered.
// ----------------------------------------------------------------------------
module tks_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               tap,
  input  logic               valid_i,
  input  tks_pkg::tks_stage_t data_i,
  output logic               valid_o,
  output tks_pkg::tks_stage_t data_o
);
  import tks_pkg::*;

  logic       valid_r;
  tks_stage_t data_r;
  tks_stage_t data_nxt;
  logic [7:0] sb;

  always_comb begin
    sb                  = SBOX[data_i.key[31:24] ^ data_i.key[7:0]];
    data_nxt            = data_i;
    data_nxt.key        = {data_i.key[23:0], sb};
    data_nxt.st1        = tks_lane_step(data_i.st1, sb);
    data_nxt.st2        = tks_lane_step(data_i.st2, sb);
    if (tap) begin
      data_nxt.ks1 = {data_i.ks1[23:0], data_nxt.st1[63:56]};
      data_nxt.ks2 = {data_i.ks2[23:0], data_nxt.st2[63:56]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;
endmodule

// File: rtl/tks_checker.sv
// ----------------------------------------------------------------------------
// tks_checker
// Port-level checks: pending items, sticky found flag, output hold and reset.
// ----------------------------------------------------------------------------
module tks_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_match,
  input logic        out_found_before,
  input logic [31:0] out_key_echo
);
  logic [7:0] pend_r;
  logic       seen_found_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= '0;
      seen_found_r <= 1'b0;
    end else begin
      pend_r <= pend_r + {7'd0, in_acc} - {7'd0, out_acc};
      if (out_acc && out_found_before) begin
        seen_found_r <= 1'b1;
      end
    end
  end

  a_no_result_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 8'd0)
    else $error("result shown with no item outstanding");

  a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_found_r |-> out_found_before)
    else $error("found flag dropped after a match");

  a_match_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match |-> out_found_before)
    else $error("match without found flag");

  a_reset_clears_out: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_echo))
    else $error("stalled result changed");
endmodule

bind tea1_short_key_search tks_checker u_tks_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_match        (out_ch.match),
  .out_found_before (out_ch.found_before),
  .out_key_echo     (out_ch.key_echo)
);
